### sv/mmm_pkg.sv
// ---------------------------------------------------------------------------
// mmm_pkg: shared definitions for the Montgomery modular multiplier
// Operand widths, accumulator width and the control/status bundles between
// the top level and the bit-serial core.
// ---------------------------------------------------------------------------
package mmm_pkg;

    // Width of every payload port
    localparam int FIELD_W = 64;
    // Operand width actually processed (8..64)
    localparam int WIDTH   = 64;
    // Accumulator carries two guard bits
    localparam int ACC_W   = WIDTH + 2;
    // Iteration counter, counts 0 .. WIDTH-1
    localparam int CNT_W   = $clog2(WIDTH);

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [WIDTH-1:0]   t_word;
    typedef logic [ACC_W-1:0]   t_acc;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Top level to core
    typedef struct packed {
        logic start;   // load operands and begin
        logic take;    // result moved to the output stage this cycle
    } t_core_ctrl;

    // Core to top level
    typedef struct packed {
        logic idle;
        logic done;    // result valid on o_result
    } t_core_stat;

endpackage

### sv/montgomery_modular_multiplier_unit.sv
// Flow: an accepted item loads the core, which consumes one bit of a per cycle
// in the accumulator loop; the result then moves to the output register and
// raises o_out_valid. A new item is taken only when the core is idle or its result moves on.
// A finished product waits in the output register while the next item runs.
// Reset: synchronous, active low; clears control state and the modulus to 0.
// ---------------------------------------------------------------------------
// montgomery_modular_multiplier_unit: radix-2 Montgomery multiplier, top level
// Returns a*b*2^-WIDTH mod N (no final subtraction) for each transferred item.
// ---------------------------------------------------------------------------
module montgomery_modular_multiplier_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  mmm_pkg::t_field i_modulus,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mmm_pkg::t_field i_multiplier_a,
    input  mmm_pkg::t_field i_multiplicand_b,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output mmm_pkg::t_field o_product
);
    import mmm_pkg::*;

    t_word      r_modulus;
    t_core_ctrl core_ctrl;
    t_core_stat core_stat;
    t_word      core_result;
    logic       out_ready;
    logic       core_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_modulus <= i_modulus[WIDTH-1:0];
        end
    end

    assign core_ctrl.take  = core_stat.done && out_ready;
    // core can load when idle or when its result leaves this cycle
    assign core_free       = core_stat.idle || core_ctrl.take;
    assign o_in_stall      = !core_free;
    assign core_ctrl.start = i_in_valid && core_free;

    mmm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (core_ctrl),
        .i_a      (i_multiplier_a[WIDTH-1:0]),
        .i_b      (i_multiplicand_b[WIDTH-1:0]),
        .i_n      (r_modulus),
        .o_stat   (core_stat),
        .o_result (core_result)
    );

    mmm_outreg u_outreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (core_stat.done),
        .i_load_data  (core_result),
        .o_load_ready (out_ready),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_product)
    );

endmodule

### sv/mmm_core.sv
// ---------------------------------------------------------------------------
// mmm_core: radix-2 Montgomery iteration engine
// Operand a drains through a shift register one bit per cycle; each cycle
// adds 0, b, N or b+N to the accumulator and halves it.
// ---------------------------------------------------------------------------
module mmm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmm_pkg::t_core_ctrl i_ctrl,
    input  mmm_pkg::t_word      i_a,
    input  mmm_pkg::t_word      i_b,
    input  mmm_pkg::t_word      i_n,
    output mmm_pkg::t_core_stat o_stat,
    output mmm_pkg::t_word      o_result
);
    import mmm_pkg::*;

    localparam t_cnt LAST_CNT = CNT_W'(WIDTH - 1);

    t_state r_state, n_state;
    t_cnt   r_cnt;
    t_word  r_a;
    t_word  r_b;
    t_word  r_n;
    t_acc   r_bn;
    t_acc   r_acc;

    logic   load;
    logic   bit_a;
    logic   odd;
    t_acc   addend;
    t_acc   sum;

    assign bit_a = r_a[0];
    // parity of acc after the optional add of b decides the add of N
    assign odd   = r_acc[0] ^ (bit_a & r_b[0]);

    always_comb begin
        addend = '0;
        if (bit_a && odd) begin
            addend = r_bn;
        end else if (bit_a) begin
            addend = ACC_W'(r_b);
        end else if (odd) begin
            addend = ACC_W'(r_n);
        end
    end

    // acc < 2^(WIDTH+1) and b+N < 2^(WIDTH+1), so the sum fits
    assign sum = r_acc + addend;

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    load    = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == LAST_CNT) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctrl.take) begin
                    if (i_ctrl.start) begin
                        load    = 1'b1;
                        n_state = S_RUN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_cnt <= '0;
            end else if (r_state == S_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_n   <= i_n;
            r_bn  <= ACC_W'(i_b) + ACC_W'(i_n);
            r_acc <= '0;
        end else if (r_state == S_RUN) begin
            r_a   <= r_a >> 1;
            r_acc <= sum >> 1;
        end
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_result    = r_acc[WIDTH-1:0];

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_ctrl.start) |=> (r_state == S_RUN && r_cnt == '0))
        else $error("core did not start on request");

    a_last_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == LAST_CNT) |=> (r_state == S_DONE))
        else $error("core ran past the last bit of a");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_ctrl.take) |=> (r_state == S_DONE && $stable(r_acc)))
        else $error("result lost before transfer");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_acc[ACC_W-1])
        else $error("accumulator exceeded its bound");

endmodule

### sv/mmm_outreg.sv
// ---------------------------------------------------------------------------
// mmm_outreg: output register stage
// Holds one finished product until the consumer takes it, freeing the core.
// ---------------------------------------------------------------------------
module mmm_outreg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load_valid,
    input  mmm_pkg::t_word  i_load_data,
    output logic            o_load_ready,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output mmm_pkg::t_field o_out_data
);
    import mmm_pkg::*;

    logic  r_valid;
    t_word r_data;
    logic  load;

    // room when empty or the held word leaves this cycle
    assign o_load_ready = !r_valid || !i_out_stall;
    assign load         = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_load_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = FIELD_W'(r_data);

endmodule
